// ----- hw/rtl/mfcd_pkg.sv -----
// Package for the median / FIR cascade / derivative block.
// Holds request and result types, FSM state type and coefficient tables.
package mfcd_pkg;

  typedef struct packed {
    logic signed [14:0] temp_centideg;
    logic [16:0]        press_pascal;
    logic               read_ok;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] temp_filtered_q31;
    logic signed [31:0] press_filtered_q31;
    logic signed [31:0] press_slope_q31;
  } out_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_WRRING,
    ST_MED,
    ST_FIRT,
    ST_FIRP,
    ST_FIRC,
    ST_SHIFT,
    ST_SLOPE,
    ST_OUT
  } state_t;

  localparam int MAIN_TABLE_LEN = 48;
  localparam int CASC_TABLE_LEN = 60;

  function automatic logic signed [31:0] main_coef(input logic [6:0] i);
    logic signed [31:0] c;
    case (i)
      7'd1: c = -32'sd51592;      7'd2: c = 32'sd217383;
      7'd3: c = -32'sd520041;     7'd4: c = 32'sd989989;
      7'd5: c = -32'sd1663815;    7'd6: c = 32'sd2581534;
      7'd7: c = -32'sd3782858;    7'd8: c = 32'sd5302796;
      7'd9: c = -32'sd7166951;    7'd10: c = 32'sd9386970;
      7'd11: c = -32'sd11956608;  7'd12: c = 32'sd14848824;
      7'd13: c = -32'sd18014276;  7'd14: c = 32'sd21381479;
      7'd15: c = -32'sd24858711;  7'd16: c = 32'sd28337660;
      7'd17: c = -32'sd31698608;  7'd18: c = 32'sd34816820;
      7'd19: c = -32'sd37569691;  7'd20: c = 32'sd39844122;
      7'd21: c = -32'sd41543568;  7'd22: c = 32'sd42594192;
      7'd23: c = 32'sd2104533549; 7'd24: c = 32'sd42594192;
      7'd25: c = -32'sd41543568;  7'd26: c = 32'sd39844122;
      7'd27: c = -32'sd37569691;  7'd28: c = 32'sd34816820;
      7'd29: c = -32'sd31698608;  7'd30: c = 32'sd28337660;
      7'd31: c = -32'sd24858711;  7'd32: c = 32'sd21381479;
      7'd33: c = -32'sd18014276;  7'd34: c = 32'sd14848824;
      7'd35: c = -32'sd11956608;  7'd36: c = 32'sd9386970;
      7'd37: c = -32'sd7166951;   7'd38: c = 32'sd5302796;
      7'd39: c = -32'sd3782858;   7'd40: c = 32'sd2581534;
      7'd41: c = -32'sd1663815;   7'd42: c = 32'sd989989;
      7'd43: c = -32'sd520041;    7'd44: c = 32'sd217383;
      7'd45: c = -32'sd51592;
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] casc_coef(input logic [6:0] i);
    logic signed [31:0] c;
    case (i)
      7'd1: c = 32'sd55180;     7'd2: c = 32'sd234079;   7'd3: c = 32'sd561317;
      7'd4: c = 32'sd1067909;   7'd5: c = 32'sd1791074;  7'd6: c = 32'sd2773355;
      7'd7: c = 32'sd4061043;   7'd8: c = 32'sd5701940;  7'd9: c = 32'sd7742576;
      7'd10: c = 32'sd10225003; 7'd11: c = 32'sd13183364; 7'd12: c = 32'sd16640454;
      7'd13: c = 32'sd20604479; 7'd14: c = 32'sd25066268; 7'd15: c = 32'sd29997136;
      7'd16: c = 32'sd35347594; 7'd17: c = 32'sd41047038; 7'd18: c = 32'sd47004522;
      7'd19: c = 32'sd53110629; 7'd20: c = 32'sd59240414; 7'd21: c = 32'sd65257315;
      7'd22: c = 32'sd71017871; 7'd23: c = 32'sd76377024; 7'd24: c = 32'sd81193762;
      7'd25: c = 32'sd85336815; 7'd26: c = 32'sd88690103; 7'd27: c = 32'sd91157665;
      7'd28: c = 32'sd92667795; 7'd29: c = 32'sd93176170; 7'd30: c = 32'sd92667795;
      7'd31: c = 32'sd91157665; 7'd32: c = 32'sd88690103; 7'd33: c = 32'sd85336815;
      7'd34: c = 32'sd81193762; 7'd35: c = 32'sd76377024; 7'd36: c = 32'sd71017871;
      7'd37: c = 32'sd65257315; 7'd38: c = 32'sd59240414; 7'd39: c = 32'sd53110629;
      7'd40: c = 32'sd47004522; 7'd41: c = 32'sd41047038; 7'd42: c = 32'sd35347594;
      7'd43: c = 32'sd29997136; 7'd44: c = 32'sd25066268; 7'd45: c = 32'sd20604479;
      7'd46: c = 32'sd16640454; 7'd47: c = 32'sd13183364; 7'd48: c = 32'sd10225003;
      7'd49: c = 32'sd7742576;  7'd50: c = 32'sd5701940;  7'd51: c = 32'sd4061043;
      7'd52: c = 32'sd2773355;  7'd53: c = 32'sd1791074;  7'd54: c = 32'sd1067909;
      7'd55: c = 32'sd561317;   7'd56: c = 32'sd234079;  7'd57: c = 32'sd55180;
      default: c = 32'sd0;
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/mfcd_mac.sv -----
// Shared multiply-accumulate unit: one 32x32 signed product per cycle while en is
// high, registered, then added into a 64-bit accumulator. Uses no package items.
module mfcd_mac (
  input  logic               clk,
  input  logic               clr,
  input  logic               en,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  input  logic               prod_vld,
  output logic [63:0]        acc_sum
);
  logic signed [63:0] prod_r;
  logic [63:0]        acc_r;
  logic [63:0]        acc_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= a * b;
    end
  end

  // acc_sum already holds the pending product, so the final tap is visible
  // in the same cycle that the accumulator is cleared for the next sum.
  always_comb begin
    acc_sum = acc_r + (prod_vld ? 64'(prod_r) : 64'd0);
    if (clr) begin
      acc_nxt = 64'd0;
    end else begin
      acc_nxt = acc_sum;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
  end
endmodule

// ----- hw/rtl/mfcd_norm.sv -----
// Q31 normalization with saturation by an exact reciprocal multiply.
// Depends on nothing but its ports.
module mfcd_norm (
  input  logic signed [17:0] num,   // sample minus offset
  input  logic               is_press,
  output logic signed [31:0] q
);
  // q = trunc(num * 2^31 / den), saturated. Below saturation |num| < den, and
  // floor(|num| * 2^31 / den) equals (|num| * ceil(2^61 / den)) >> 30 for
  // both divisors, because the rounding error of the reciprocal times
  // |num| * 2^31 stays below 2^61.
  logic [17:0] mag;
  logic [16:0] den;
  logic [47:0] recip;
  logic [65:0] prod;
  logic        neg;

  always_comb begin
    neg   = num[17];
    mag   = neg ? 18'(-num) : 18'(num);
    den   = is_press ? 17'd100000 : 17'd10000;
    recip = is_press ? 48'd23058430092137 : 48'd230584300921370;
    prod  = 66'(mag) * 66'(recip);
    if (mag >= 18'(den)) begin
      q = neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      q = neg ? -$signed(prod[61:30]) : $signed(prod[61:30]);
    end
  end
endmodule

// ----- hw/rtl/median_fir_cascade_derivative.sv -----
// Median / FIR cascade / derivative filter for a temperature and pressure
// sample pair.
//
// Input channel (in_valid/in_stall/in_req): one request carries one sample
// pair and a read_ok flag. A request with read_ok low is taken and produces
// nothing. A good request is normalized to Q31, written into the median
// rings, and then its two medians are found by a serial rank count
// (MEDIAN_LEN squared compare steps, both channels side by side). Each FIR
// is run on the single shared multiply-accumulate unit, one tap per cycle,
// and then its finished sum is captured. out_valid rises after the three
// FIRs (temperature, pressure, cascade), the delay-line shift and the slope
// step. in_stall is high from acceptance until the result has been taken.
// Output channel (out_valid/out_stall/out_res): the result is held in an
// output register until taken; the block waits while out_stall is high.
// Reset (rst_n low, synchronous) clears the rings, delay lines, slope
// history and sequencer; delay lines are shift registers that rotate during
// their FIR so that each is read only at its oldest stage.
module median_fir_cascade_derivative #(
  parameter int MAIN_TAPS    = 48,
  parameter int CASCADE_TAPS = 60,
  parameter int MEDIAN_LEN   = 5
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mfcd_pkg::in_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output mfcd_pkg::out_res_t out_res
);
  localparam int MW = $clog2(MEDIAN_LEN);
  localparam int TW = 7;

  mfcd_pkg::state_t state_r, state_nxt;

  logic signed [31:0] tring_r [MEDIAN_LEN];
  logic signed [31:0] pring_r [MEDIAN_LEN];
  logic [MW-1:0]      slot_r;
  logic signed [31:0] tdl_r [MAIN_TAPS-1];
  logic signed [31:0] pdl_r [MAIN_TAPS-1];
  logic signed [31:0] cdl_r [CASCADE_TAPS-1];
  logic signed [31:0] prev1_r, prev2_r;

  logic signed [31:0] tn_r, pn_r, tq, pq;
  logic signed [31:0] tmed_r, pmed_r, tf_r, pf_r, cf_r;
  logic [MW-1:0]      mi_r, mj_r;
  logic [MW:0]        tlt_r, tle_r, plt_r, ple_r;
  logic [TW-1:0]      tap_r;
  logic               pvld_r, last_r;
  logic               mac_clr, mac_en;
  logic signed [31:0] mac_a, mac_b;
  logic [63:0]        acc;
  logic signed [31:0] samp;
  logic [TW-1:0]      taps_cur;
  logic               newest_tap, rot_en;

  mfcd_norm u_tn (.num(18'($signed(in_req.temp_centideg)) - 18'sd2000),
                  .is_press(1'b0), .q(tq));
  mfcd_norm u_pn (.num($signed({1'b0, in_req.press_pascal}) - 18'sd80000),
                  .is_press(1'b1), .q(pq));

  mfcd_mac u_mac (.clk(clk), .clr(mac_clr), .en(mac_en), .a(mac_a), .b(mac_b),
                  .prod_vld(pvld_r), .acc_sum(acc));

  // Tap count of the FIR now running.
  assign taps_cur = (state_r == mfcd_pkg::ST_FIRC) ? TW'(CASCADE_TAPS) : TW'(MAIN_TAPS);

  // Sample at tap i is x[n-(TAPS-1-i)]: the oldest sample at tap 0 and the
  // newest at the last tap. The delay line rotates one stage per tap, so the
  // sample needed next sits in its last stage; the newest comes from outside it.
  always_comb begin
    newest_tap = (tap_r == taps_cur - TW'(1));
    case (state_r)
      mfcd_pkg::ST_FIRT: samp = newest_tap ? tmed_r : tdl_r[MAIN_TAPS-2];
      mfcd_pkg::ST_FIRP: samp = newest_tap ? pmed_r : pdl_r[MAIN_TAPS-2];
      default:           samp = newest_tap ? pf_r : cdl_r[CASCADE_TAPS-2];
    endcase
    mac_a = samp;
    mac_b = (state_r == mfcd_pkg::ST_FIRC) ? mfcd_pkg::casc_coef(tap_r)
                                           : mfcd_pkg::main_coef(tap_r);
    mac_en = (state_r == mfcd_pkg::ST_FIRT) || (state_r == mfcd_pkg::ST_FIRP) ||
             (state_r == mfcd_pkg::ST_FIRC);
    rot_en = mac_en && !last_r && !newest_tap;
    // The accumulator restarts once the finished sum has been captured.
    mac_clr = (state_r == mfcd_pkg::ST_MED) || last_r;
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfcd_pkg::ST_IDLE:
        if (in_valid && in_req.read_ok) state_nxt = mfcd_pkg::ST_NORM;
      mfcd_pkg::ST_NORM:   state_nxt = mfcd_pkg::ST_WRRING;
      mfcd_pkg::ST_WRRING: state_nxt = mfcd_pkg::ST_MED;
      mfcd_pkg::ST_MED:
        if (mi_r == MW'(MEDIAN_LEN - 1) && mj_r == MW'(MEDIAN_LEN - 1))
          state_nxt = mfcd_pkg::ST_FIRT;
      mfcd_pkg::ST_FIRT:
        if (last_r) state_nxt = mfcd_pkg::ST_FIRP;
      mfcd_pkg::ST_FIRP:
        if (last_r) state_nxt = mfcd_pkg::ST_FIRC;
      mfcd_pkg::ST_FIRC:
        if (last_r) state_nxt = mfcd_pkg::ST_SHIFT;
      mfcd_pkg::ST_SHIFT:  state_nxt = mfcd_pkg::ST_SLOPE;
      mfcd_pkg::ST_SLOPE:  state_nxt = mfcd_pkg::ST_OUT;
      mfcd_pkg::ST_OUT:
        if (!out_stall) state_nxt = mfcd_pkg::ST_IDLE;
      default:             state_nxt = mfcd_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = (state_r != mfcd_pkg::ST_IDLE);
    out_valid = (state_r == mfcd_pkg::ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= mfcd_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  // The product register holds the product of the tap counted in the cycle
  // before; last_r marks the cycle whose product is the final tap, and in
  // that cycle the MAC sum output already includes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pvld_r <= 1'b0;
      last_r <= 1'b0;
      tap_r  <= '0;
    end else begin
      pvld_r <= mac_en && !last_r;
      if (mac_en && !last_r) begin
        if (tap_r == taps_cur - TW'(1)) begin
          last_r <= 1'b1;
          tap_r  <= '0;
        end else begin
          tap_r <= tap_r + TW'(1);
        end
      end else begin
        last_r <= 1'b0;
      end
    end
  end

  // Median by rank count: entry i is the median if fewer than MEDIAN_LEN/2+1
  // are below it and at least MEDIAN_LEN/2+1 are at or below it.
  always_ff @(posedge clk) begin
    if (state_r == mfcd_pkg::ST_WRRING) begin
      mi_r <= '0;
      mj_r <= '0;
      tlt_r <= '0; tle_r <= '0; plt_r <= '0; ple_r <= '0;
    end else if (state_r == mfcd_pkg::ST_MED) begin
      logic [MW:0] tl, te, pl, pe;
      tl = tlt_r + (MW+1)'(tring_r[mj_r] < tring_r[mi_r]);
      te = tle_r + (MW+1)'(tring_r[mj_r] <= tring_r[mi_r]);
      pl = plt_r + (MW+1)'(pring_r[mj_r] < pring_r[mi_r]);
      pe = ple_r + (MW+1)'(pring_r[mj_r] <= pring_r[mi_r]);
      if (mj_r == MW'(MEDIAN_LEN - 1)) begin
        if (tl <= (MW+1)'(MEDIAN_LEN / 2) && te > (MW+1)'(MEDIAN_LEN / 2))
          tmed_r <= tring_r[mi_r];
        if (pl <= (MW+1)'(MEDIAN_LEN / 2) && pe > (MW+1)'(MEDIAN_LEN / 2))
          pmed_r <= pring_r[mi_r];
        tlt_r <= '0; tle_r <= '0; plt_r <= '0; ple_r <= '0;
        mj_r <= '0;
        mi_r <= mi_r + MW'(1);
      end else begin
        tlt_r <= tl; tle_r <= te; plt_r <= pl; ple_r <= pe;
        mj_r <= mj_r + MW'(1);
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (state_r == mfcd_pkg::ST_IDLE) begin
      tn_r <= tq;
      pn_r <= pq;
    end
    if (state_r == mfcd_pkg::ST_FIRT && last_r) tf_r <= acc[62:31];
    if (state_r == mfcd_pkg::ST_FIRP && last_r) pf_r <= acc[62:31];
    if (state_r == mfcd_pkg::ST_FIRC && last_r) cf_r <= acc[62:31];
    if (state_r == mfcd_pkg::ST_SLOPE) begin
      logic signed [31:0] d;
      d = 32'(cf_r * 3) - 32'(prev1_r * 4) + prev2_r;
      out_res.temp_filtered_q31  <= tf_r;
      out_res.press_filtered_q31 <= pf_r;
      // Adding the sign bit before the arithmetic shift rounds toward zero.
      out_res.press_slope_q31    <= (d + $signed(32'(d[31]))) >>> 1;
    end
  end

  // State that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r  <= '0;
      prev1_r <= '0;
      prev2_r <= '0;
      for (int i = 0; i < MEDIAN_LEN; i++) begin
        tring_r[i] <= '0;
        pring_r[i] <= '0;
      end
      for (int i = 0; i < MAIN_TAPS - 1; i++) begin
        tdl_r[i] <= '0;
        pdl_r[i] <= '0;
      end
      for (int i = 0; i < CASCADE_TAPS - 1; i++) cdl_r[i] <= '0;
    end else begin
      if (state_r == mfcd_pkg::ST_NORM) begin
        tring_r[slot_r] <= tn_r;
        pring_r[slot_r] <= pn_r;
        slot_r <= (slot_r == MW'(MEDIAN_LEN - 1)) ? '0 : slot_r + MW'(1);
      end
      // One full turn of rotation over the taps leaves each line as it was.
      if (rot_en && state_r == mfcd_pkg::ST_FIRT) begin
        for (int i = MAIN_TAPS - 2; i > 0; i--) tdl_r[i] <= tdl_r[i-1];
        tdl_r[0] <= tdl_r[MAIN_TAPS-2];
      end
      if (rot_en && state_r == mfcd_pkg::ST_FIRP) begin
        for (int i = MAIN_TAPS - 2; i > 0; i--) pdl_r[i] <= pdl_r[i-1];
        pdl_r[0] <= pdl_r[MAIN_TAPS-2];
      end
      if (rot_en && state_r == mfcd_pkg::ST_FIRC) begin
        for (int i = CASCADE_TAPS - 2; i > 0; i--) cdl_r[i] <= cdl_r[i-1];
        cdl_r[0] <= cdl_r[CASCADE_TAPS-2];
      end
      if (state_r == mfcd_pkg::ST_SHIFT) begin
        for (int i = MAIN_TAPS - 2; i > 0; i--) begin
          tdl_r[i] <= tdl_r[i-1];
          pdl_r[i] <= pdl_r[i-1];
        end
        tdl_r[0] <= tmed_r;
        pdl_r[0] <= pmed_r;
        for (int i = CASCADE_TAPS - 2; i > 0; i--) cdl_r[i] <= cdl_r[i-1];
        cdl_r[0] <= pf_r;
      end
      if (state_r == mfcd_pkg::ST_SLOPE) begin
        prev2_r <= prev1_r;
        prev1_r <= cf_r;
      end
    end
  end
endmodule
